// ----- hw/rtl/forward_count_table_with_aging_assert.svh -----
// Assertion macros for the forward count table.
// Included by the RTL files that carry concurrent checks; depends on nothing else.
`ifndef FORWARD_COUNT_TABLE_WITH_AGING_ASSERT_SVH
`define FORWARD_COUNT_TABLE_WITH_AGING_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define FCTA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define FCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FCTA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/fcta_pkg.sv -----
// Types and codes for the forward count table with aging.
// No dependencies; imported by forward_count_table_with_aging.
package fcta_pkg;

    typedef logic [1:0]  t_cmd;
    typedef logic [2:0]  t_status;
    typedef logic [13:0] t_msg_id;
    typedef logic [31:0] t_time;
    typedef logic [7:0]  t_count;
    typedef logic [4:0]  t_removed;
    typedef logic        t_cfg_index;

    // Command codes
    localparam t_cmd CMD_RECORD   = 2'd0;
    localparam t_cmd CMD_QUERY    = 2'd1;
    localparam t_cmd CMD_SWEEP    = 2'd2;
    localparam t_cmd CMD_RESERVED = 2'd3;

    // Result status codes
    localparam t_status STAT_UPDATED  = 3'd0;
    localparam t_status STAT_INSERTED = 3'd1;
    localparam t_status STAT_FULL     = 3'd2;
    localparam t_status STAT_HIT      = 3'd3;
    localparam t_status STAT_MISS     = 3'd4;
    localparam t_status STAT_SWEPT    = 3'd5;

    // Configuration register indexes
    localparam t_cfg_index REG_EXPIRY  = 1'b0;
    localparam t_cfg_index REG_MAX_FWD = 1'b1;

    // Configuration reset values
    localparam t_time  EXPIRY_RESET  = 32'd60000;
    localparam t_count MAX_FWD_RESET = 8'd3;

    localparam t_count   COUNT_MAX   = 8'd255;
    localparam t_removed REMOVED_MAX = 5'd31;

    // One table entry as held in the entry memory
    typedef struct packed {
        t_msg_id id;
        t_time   start;
        t_count  wifi;
        t_count  radio;
    } t_entry;

endpackage

// ----- hw/rtl/forward_count_table_with_aging.sv -----
// Forward count table with aging: top level.
// Depends on fcta_pkg and forward_count_table_with_aging_assert.svh.
//
// Tracks per-message forward counts on two links in a table of ENTRIES slots.
// Each transaction (record, query or sweep) is handled by one sequencer that walks
// the table one entry per cycle through an entry memory with one write and one read
// port and one shared compare/subtract unit. A transaction is accepted in idle, scans
// entries (record and query stop at the matching entry) and then posts the result. A
// sweep, an insert, a full table or a query miss scans all entries. The post step also
// waits for as long as the previous result is still held at the output. The input is
// not ready from the accept until the sequencer is back in idle. Command 3 is
// accepted and dropped without a result.
// Valid bits live in flip-flops, so the table is empty right after reset and
// needs no clearing pass.
module forward_count_table_with_aging #(
    parameter int ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  fcta_pkg::t_cfg_index  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fcta_pkg::t_cmd        i_command,
    input  fcta_pkg::t_msg_id     i_msg_id,
    input  logic                  i_on_wifi,
    input  fcta_pkg::t_time       i_now_ms,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fcta_pkg::t_status     o_status,
    output fcta_pkg::t_count      o_forward_count,
    output fcta_pkg::t_removed    o_removed_count
);
    import fcta_pkg::*;

`include "forward_count_table_with_aging_assert.svh"

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Control registers
    logic [1:0]         r_state, n_state;
    logic [IW-1:0]      r_idx, n_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic               r_free_found, n_free_found;
    logic               r_out_valid, n_out_valid;
    t_time              r_expiry, n_expiry;
    t_count             r_max_fwd, n_max_fwd;

    // Payload registers
    t_cmd     r_cmd, n_cmd;
    t_msg_id  r_id, n_id;
    logic     r_wifi, n_wifi;
    t_time    r_now, n_now;
    logic [IW-1:0] r_free_idx, n_free_idx;
    t_removed r_removed, n_removed;
    t_status  r_res_status, n_res_status;
    t_count   r_res_count, n_res_count;
    t_status  r_out_status, n_out_status;
    t_count   r_out_count, n_out_count;
    t_removed r_out_removed, n_out_removed;

    // Entry memory: one write port, one registered read port
    t_entry        r_mem [ENTRIES];
    t_entry        r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [IW-1:0] rd_addr;

    // Shared compare unit working on the entry under the scan pointer
    logic    cur_valid;
    logic    hit;
    t_count  cur_cnt;
    t_count  inc_cnt;
    t_time   age;
    logic    expired;
    logic    done_both;
    logic    last;
    logic    in_accept;
    logic [IW-1:0] ins_slot;

    // Check conditions
    logic    sweep_scan;
    logic    query_scan;
    logic    out_other;
    logic    out_full;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign cur_valid = r_valid[r_idx];
    assign hit       = cur_valid && (r_rd.id == r_id);
    assign cur_cnt   = r_wifi ? r_rd.wifi : r_rd.radio;
    assign inc_cnt   = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 8'd1;
    assign age       = r_now - r_rd.start;
    assign expired   = age > r_expiry;
    assign done_both = (r_rd.wifi == r_max_fwd) && (r_rd.radio == r_max_fwd);
    assign last      = (r_idx == LAST);
    assign ins_slot  = r_free_found ? r_free_idx : r_idx;

    // Sequencer and datapath next state
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_wifi       = r_wifi;
        n_now        = r_now;
        n_removed    = r_removed;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        n_expiry     = r_expiry;
        n_max_fwd    = r_max_fwd;

        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;
        n_out_removed = r_out_removed;

        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rd;
        rd_addr   = r_idx + {{(IW-1){1'b0}}, 1'b1};

        // configuration writes, taken in any state
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EXPIRY:  n_expiry  = i_cfg_data;
                REG_MAX_FWD: n_max_fwd = i_cfg_data[7:0];
            endcase
        end

        case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (in_accept) begin
                    n_cmd        = i_command;
                    n_id         = i_msg_id;
                    n_wifi       = i_on_wifi;
                    n_now        = i_now_ms;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_removed    = '0;
                    if (i_command != CMD_RESERVED) begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                n_idx = r_idx + {{(IW-1){1'b0}}, 1'b1};
                unique case (r_cmd)
                    CMD_RECORD: begin
                        if (hit) begin
                            // bump the chosen link's count in place
                            mem_we    = 1'b1;
                            mem_waddr = r_idx;
                            mem_wdata = r_rd;
                            if (r_wifi) begin
                                mem_wdata.wifi = inc_cnt;
                            end else begin
                                mem_wdata.radio = inc_cnt;
                            end
                            n_res_status = STAT_UPDATED;
                            n_res_count  = inc_cnt;
                            n_state      = S_DONE;
                        end else begin
                            // remember the lowest free slot
                            if (!cur_valid && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_idx;
                            end
                            if (last) begin
                                if (r_free_found || !cur_valid) begin
                                    mem_we          = 1'b1;
                                    mem_waddr       = ins_slot;
                                    mem_wdata.id    = r_id;
                                    mem_wdata.start = r_now;
                                    mem_wdata.wifi  = r_wifi ? 8'd1 : 8'd0;
                                    mem_wdata.radio = r_wifi ? 8'd0 : 8'd1;
                                    n_valid[ins_slot] = 1'b1;
                                    n_res_status = STAT_INSERTED;
                                    n_res_count  = 8'd1;
                                end else begin
                                    n_res_status = STAT_FULL;
                                    n_res_count  = '0;
                                end
                                n_state = S_DONE;
                            end
                        end
                    end
                    CMD_QUERY: begin
                        if (hit) begin
                            n_res_status = STAT_HIT;
                            n_res_count  = cur_cnt;
                            n_state      = S_DONE;
                        end else if (last) begin
                            n_res_status = STAT_MISS;
                            n_res_count  = '0;
                            n_state      = S_DONE;
                        end
                    end
                    CMD_SWEEP: begin
                        // age out stale entries and entries done on both links
                        if (cur_valid && (expired || done_both)) begin
                            n_valid[r_idx] = 1'b0;
                            if (r_removed != REMOVED_MAX) begin
                                n_removed = r_removed + 5'd1;
                            end
                        end
                        if (last) begin
                            n_res_status = STAT_SWEPT;
                            n_res_count  = '0;
                            n_state      = S_DONE;
                        end
                    end
                    CMD_RESERVED: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_DONE: begin
                // post the result once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_count   = r_res_count;
                    n_out_removed = r_removed;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
            r_expiry     <= EXPIRY_RESET;
            r_max_fwd    <= MAX_FWD_RESET;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_valid      <= n_valid;
            r_free_found <= n_free_found;
            r_out_valid  <= n_out_valid;
            r_expiry     <= n_expiry;
            r_max_fwd    <= n_max_fwd;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_id          <= n_id;
        r_wifi        <= n_wifi;
        r_now         <= n_now;
        r_free_idx    <= n_free_idx;
        r_removed     <= n_removed;
        r_res_status  <= n_res_status;
        r_res_count   <= n_res_count;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
        r_out_removed <= n_out_removed;
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_forward_count = r_out_count;
    assign o_removed_count = r_out_removed;

    // Checks
    assign sweep_scan = (r_state == S_SCAN) && (r_cmd == CMD_SWEEP);
    assign query_scan = (r_state == S_SCAN) && (r_cmd == CMD_QUERY);
    assign out_other  = o_out_valid && (o_status != STAT_SWEPT);
    assign out_full   = o_out_valid && (o_status == STAT_FULL);

    `FCTA_ASSERT_IMPL(a_removed_only_on_sweep, i_clk, i_rst_n, out_other, o_removed_count == '0)
    `FCTA_ASSERT_IMPL(a_full_has_no_count, i_clk, i_rst_n, out_full, o_forward_count == '0)
    `FCTA_ASSERT_IMPL(a_sweep_never_adds, i_clk, i_rst_n, sweep_scan, (n_valid & ~r_valid) == '0)
    `FCTA_ASSERT_NEXT(a_query_keeps_table, i_clk, i_rst_n, query_scan, r_valid == $past(r_valid))

endmodule
